// File: hdl/growing_degree_day_stage_tracker_assert.svh
// Assertion macros shared by the tracker RTL.
`ifndef GROWING_DEGREE_DAY_STAGE_TRACKER_ASSERT_SVH
`define GROWING_DEGREE_DAY_STAGE_TRACKER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define GDD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define GDD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/gdd_pkg.sv
// Types and constants shared by the growing degree day tracker.
`timescale 1ns / 1ps
`default_nettype none

package gdd_pkg;

	localparam int TEMP_W   = 15;
	localparam int THR_W    = 20;
	localparam int RUN_W    = 18;
	localparam int UNITS_W  = 20;
	localparam int DAYS_W   = 16;
	localparam int ACC_W    = 24;
	localparam int STAGE_W  = 3;
	localparam int PCT_W    = 7;
	localparam int BAR_W    = 5;
	localparam int CFG_IDX_W = 3;
	localparam int NUM_THR  = 6;
	// numerator of progress division: total below threshold (20 bits) times up to 100
	localparam int NUM_W    = 27;
	localparam int QUO_W    = 7;

	localparam logic [CFG_IDX_W-1:0] REG_BASE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THR1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THR6 = 3'd6;

	localparam logic signed [TEMP_W-1:0] BASE_RESET = 15'sd1000;
	localparam logic [THR_W-1:0] THR_RESET [NUM_THR] = '{
		20'd1289, 20'd6441, 20'd9133, 20'd9931, 20'd11277, 20'd15324
	};

	localparam logic signed [RUN_W-1:0] MAX_EMPTY = -18'sd99900;
	localparam logic signed [RUN_W-1:0] MIN_EMPTY = 18'sd99900;

	localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
	localparam logic [QUO_W-1:0] PCT_SCALE = 7'd100;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UPDATE,
		S_ADD,
		S_STAGE,
		S_PREPP,
		S_DIVP,
		S_PREPB,
		S_DIVB,
		S_DONE
	} state_t;

	typedef struct packed {
		logic                     upd;
		logic                     close;
		logic                     add;
		logic signed [TEMP_W-1:0] temperature;
	} day_ctrl_t;

endpackage

`default_nettype wire

// File: hdl/gdd_cmpsub.sv
// Shared compare and subtract unit used for stage checks and division steps.
`timescale 1ns / 1ps
`default_nettype none

module gdd_cmpsub #(
	parameter int W = 28
) (
	input  wire logic [W-1:0] a,
	input  wire logic [W-1:0] b,
	output logic              ge,
	output logic [W-1:0]      diff
);
	logic [W:0] wide;

	assign wide = {1'b0, a} - {1'b0, b};
	// no borrow out means a >= b
	assign ge   = ~wide[W];
	assign diff = wide[W-1:0];
endmodule

`default_nettype wire

// File: hdl/gdd_day.sv
// Daily extremes, heat units, day counter and saturating heat total.
`timescale 1ns / 1ps
`default_nettype none

module gdd_day #(
	parameter int TOTAL_WIDTH = 24
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire gdd_pkg::day_ctrl_t                   ctrl,
	input  wire logic signed [gdd_pkg::TEMP_W-1:0]    base,
	output logic signed [gdd_pkg::RUN_W-1:0]          shown_max,
	output logic signed [gdd_pkg::RUN_W-1:0]          shown_min,
	output logic [gdd_pkg::UNITS_W-1:0]               units,
	output logic [gdd_pkg::DAYS_W-1:0]                days,
	output logic [TOTAL_WIDTH-1:0]                    total
);
	import gdd_pkg::*;

	localparam int SW = ((TOTAL_WIDTH > UNITS_W) ? TOTAL_WIDTH : UNITS_W) + 1;

	logic signed [RUN_W-1:0] max_q, min_q, shown_max_q, shown_min_q;
	logic [UNITS_W-1:0]      units_q;
	logic [DAYS_W-1:0]       days_q;
	logic [TOTAL_WIDTH-1:0]  total_q;

	logic signed [RUN_W-1:0] t_ext, max_new, min_new;
	logic signed [20:0]      d;
	logic [UNITS_W-1:0]      units_new;
	logic [SW-1:0]           tsum;
	logic                    tsat;

	assign t_ext   = RUN_W'(ctrl.temperature);
	assign max_new = (t_ext > max_q) ? t_ext : max_q;
	assign min_new = (t_ext < min_q) ? t_ext : min_q;

	// twice the mean minus twice the base; halve only when positive
	assign d         = 21'(max_q) + 21'(min_q) - 21'(base) - 21'(base);
	assign units_new = (d <= 21'sd0) ? '0 : UNITS_W'(d >>> 1);

	assign tsum = SW'(total_q) + SW'(units_q);
	assign tsat = tsum > SW'({TOTAL_WIDTH{1'b1}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q   <= MAX_EMPTY;
			min_q   <= MIN_EMPTY;
			units_q <= '0;
			days_q  <= '0;
			total_q <= '0;
		end else begin
			if (ctrl.upd && !ctrl.close) begin
				max_q <= max_new;
				min_q <= min_new;
			end
			if (ctrl.upd && ctrl.close) begin
				units_q <= units_new;
				max_q   <= MAX_EMPTY;
				min_q   <= MIN_EMPTY;
				if (days_q != {DAYS_W{1'b1}}) begin
					days_q <= days_q + DAYS_W'(1);
				end
			end
			if (ctrl.add) begin
				total_q <= tsat ? {TOTAL_WIDTH{1'b1}} : TOTAL_WIDTH'(tsum);
			end
		end
	end

	// values shown with the result: new extremes on a sample, closed day's on a close
	always_ff @(posedge clk) begin
		if (ctrl.upd) begin
			shown_max_q <= ctrl.close ? max_q : max_new;
			shown_min_q <= ctrl.close ? min_q : min_new;
		end
	end

	assign shown_max = shown_max_q;
	assign shown_min = shown_min_q;
	assign units     = units_q;
	assign days      = days_q;
	assign total     = total_q;
endmodule

`default_nettype wire

// File: hdl/growing_degree_day_stage_tracker.sv
// Growing degree day tracker: sequencer, configuration and result register.
//
// Input channel (in_valid/in_ready): func 0 is a temperature sample in
// hundredths of a degree C, func 1 closes the current day. Each request gives
// exactly one result on the output channel (out_valid/out_ready).
// A day close takes an extra add step before the stage checks; once the total
// has reached the final threshold the division is skipped. All steps share the
// single compare/subtract unit: six threshold checks, then two 7-step restoring
// divisions for percent and bar progress. in_ready is high only while the
// sequencer is idle, so one request is in work at a time; the next is accepted
// at the edge after the result is loaded into the output register.
// The result sits in an output register; a new request is accepted while it
// waits. If the receiver stalls, the next result holds in the sequencer until
// the register frees up, and in_ready stays low meanwhile.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 base
// temperature, 1..6 stage thresholds) at the clock edge; write only when idle.
// Reset (arst_n low) restores default registers, empty day, zero total.
`timescale 1ns / 1ps
`default_nettype none

module growing_degree_day_stage_tracker #(
	parameter int BAR_STEPS   = 30,
	parameter int TOTAL_WIDTH = 24
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [gdd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [gdd_pkg::THR_W-1:0]           cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                func,
	input  wire logic signed [gdd_pkg::TEMP_W-1:0]   temperature,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic                                     day_closed,
	output logic [gdd_pkg::DAYS_W-1:0]               day_count,
	output logic signed [gdd_pkg::RUN_W-1:0]         day_maximum,
	output logic signed [gdd_pkg::RUN_W-1:0]         day_minimum,
	output logic [gdd_pkg::UNITS_W-1:0]              daily_units,
	output logic [gdd_pkg::ACC_W-1:0]                accumulated_units,
	output logic [gdd_pkg::STAGE_W-1:0]              growth_stage,
	output logic [gdd_pkg::PCT_W-1:0]                progress_percent,
	output logic [gdd_pkg::BAR_W-1:0]                bar_fill
);
	import gdd_pkg::*;

	localparam int TW = TOTAL_WIDTH;
	localparam int UW = (TW > NUM_W) ? TW : NUM_W;
	localparam logic [QUO_W-1:0] BAR_K = QUO_W'(BAR_STEPS);

	state_t state_q, state_d;

	logic signed [TEMP_W-1:0] base_q;
	logic [THR_W-1:0]         thr_q [NUM_THR];

	logic                     func_q;
	logic signed [TEMP_W-1:0] temp_q;
	logic [2:0]               cnt_q;
	logic [STAGE_W-1:0]       stage_q;
	logic                     cap_q;
	logic [NUM_W-1:0]         rem_q, dv_q;
	logic [QUO_W-1:0]         quo_q, pct_q;

	logic                     out_valid_q;
	logic                     closed_q;
	logic [DAYS_W-1:0]        count_q;
	logic signed [RUN_W-1:0]  omax_q, omin_q;
	logic [UNITS_W-1:0]       ounits_q;
	logic [ACC_W-1:0]         oacc_q;
	logic [STAGE_W-1:0]       ostage_q;
	logic [PCT_W-1:0]         opct_q;
	logic [BAR_W-1:0]         obar_q;

	day_ctrl_t                ctrl;
	logic signed [RUN_W-1:0]  shown_max, shown_min;
	logic [UNITS_W-1:0]       units;
	logic [DAYS_W-1:0]        days;
	logic [TW-1:0]            total;

	logic [UW-1:0]            op_a, op_b, diff;
	logic                     ge;
	logic                     use_stage;
	logic                     load_out;
	logic [THR_W-1:0]         total20;
	logic [NUM_W-1:0]         prod;

	gdd_day #(
		.TOTAL_WIDTH(TW)
	) u_day (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.base     (base_q),
		.shown_max(shown_max),
		.shown_min(shown_min),
		.units    (units),
		.days     (days),
		.total    (total)
	);

	gdd_cmpsub #(
		.W(UW)
	) u_cmpsub (
		.a   (op_a),
		.b   (op_b),
		.ge  (ge),
		.diff(diff)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
			for (int i = 0; i < NUM_THR; i++) begin
				thr_q[i] <= THR_RESET[i];
			end
		end else if (cfg_we) begin
			if (cfg_index == REG_BASE) begin
				base_q <= cfg_data[TEMP_W-1:0];
			end else if (cfg_index >= REG_THR1 && cfg_index <= REG_THR6) begin
				thr_q[cfg_index - REG_THR1] <= cfg_data;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (in_valid) state_d = S_UPDATE;
			S_UPDATE: state_d = func_q ? S_ADD : S_STAGE;
			S_ADD:    state_d = S_STAGE;
			S_STAGE:  if (cnt_q == 3'(NUM_THR - 1)) state_d = ge ? S_DONE : S_PREPP;
			S_PREPP:  state_d = S_DIVP;
			S_DIVP:   if (cnt_q == 3'(QUO_W - 1)) state_d = S_PREPB;
			S_PREPB:  state_d = S_DIVB;
			S_DIVB:   if (cnt_q == 3'(QUO_W - 1)) state_d = S_DONE;
			S_DONE:   if (!out_valid_q || out_ready) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready          = (state_q == S_IDLE);
		ctrl.upd          = (state_q == S_UPDATE);
		ctrl.add          = (state_q == S_ADD);
		ctrl.close        = func_q;
		ctrl.temperature  = temp_q;
		use_stage         = (state_q == S_STAGE);
		load_out          = (state_q == S_DONE) && (!out_valid_q || out_ready);
	end

	assign op_a = use_stage ? UW'(total) : UW'(rem_q);
	assign op_b = use_stage ? UW'(thr_q[cnt_q]) : UW'(dv_q);

	// total is below the final threshold whenever the divisions run
	assign total20 = THR_W'(total);
	assign prod    = NUM_W'(total20) *
		NUM_W'((state_q == S_PREPP) ? PCT_SCALE : BAR_K);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_STAGE || state_q == S_DIVP || state_q == S_DIVB) begin
				cnt_q <= cnt_q + 3'd1;
			end else begin
				cnt_q <= '0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request capture and shared-unit datapath
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_q <= func;
			temp_q <= temperature;
		end
		case (state_q)
			S_UPDATE: stage_q <= '0;
			S_STAGE: begin
				stage_q <= stage_q + STAGE_W'(ge);
				if (cnt_q == 3'(NUM_THR - 1)) begin
					cap_q <= ge;
				end
			end
			S_PREPP, S_PREPB: begin
				if (state_q == S_PREPB) begin
					pct_q <= quo_q;
				end
				rem_q <= prod;
				dv_q  <= NUM_W'(thr_q[NUM_THR-1]) << (QUO_W - 1);
				quo_q <= '0;
			end
			S_DIVP, S_DIVB: begin
				if (ge) begin
					rem_q <= NUM_W'(diff);
				end
				quo_q <= {quo_q[QUO_W-2:0], ge};
				dv_q  <= dv_q >> 1;
			end
			default: begin
			end
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (load_out) begin
			closed_q <= func_q;
			count_q  <= days;
			omax_q   <= shown_max;
			omin_q   <= shown_min;
			ounits_q <= units;
			oacc_q   <= ACC_W'(total);
			ostage_q <= stage_q;
			opct_q   <= cap_q ? PCT_FULL : PCT_W'(pct_q);
			obar_q   <= cap_q ? BAR_W'(BAR_STEPS) : BAR_W'(quo_q);
		end
	end

	assign out_valid         = out_valid_q;
	assign day_closed        = closed_q;
	assign day_count         = count_q;
	assign day_maximum       = omax_q;
	assign day_minimum       = omin_q;
	assign daily_units       = ounits_q;
	assign accumulated_units = oacc_q;
	assign growth_stage      = ostage_q;
	assign progress_percent  = opct_q;
	assign bar_fill          = obar_q;

	`include "growing_degree_day_stage_tracker_assert.svh"

	`GDD_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_q == S_UPDATE, "accept did not start update")
	`GDD_ASSERT_NEXT(a_stage_exit, state_q == S_STAGE && cnt_q == 3'(NUM_THR - 1), state_q == S_PREPP || state_q == S_DONE, "stage scan overran")
	`GDD_ASSERT_NOW(a_pct_range, out_valid_q, opct_q <= PCT_FULL && ostage_q <= STAGE_W'(NUM_THR), "progress or stage out of range")
	`GDD_ASSERT_NOW(a_close_counts, out_valid_q && closed_q, count_q != '0, "day close without day count")
endmodule

`default_nettype wire

// File: verif/testbench.sv
// Testbench for the growing degree day tracker: directed and random requests, self-checking.
`timescale 1ns / 1ps

module testbench;
	import gdd_pkg::*;

	localparam int BAR_STEPS     = 30;
	localparam int TOTAL_WIDTH   = 24;
	localparam int QUIET_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 40;
	localparam int REPORT_LIMIT  = 50;
	localparam int DAYS_MAX      = 65535;
	localparam int SHORT_DAYS    = 20;
	localparam longint TOTAL_MAX = (64'd1 << TOTAL_WIDTH) - 1;
	localparam longint UNITS_MAX = (64'd1 << UNITS_W) - 1;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_CLOSE  = 1'b1;

	typedef struct {
		logic                    day_closed;
		logic [DAYS_W-1:0]       day_count;
		logic signed [RUN_W-1:0] day_maximum;
		logic signed [RUN_W-1:0] day_minimum;
		logic [UNITS_W-1:0]      daily_units;
		logic [ACC_W-1:0]        accumulated_units;
		logic [STAGE_W-1:0]      growth_stage;
		logic [PCT_W-1:0]        progress_percent;
		logic [BAR_W-1:0]        bar_fill;
	} day_result_t;

	logic                     clk;
	logic                     arst_n      = 1'b0;
	logic                     cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index   = '0;
	logic [THR_W-1:0]         cfg_data    = '0;
	logic                     in_valid    = 1'b0;
	logic                     func        = 1'b0;
	logic signed [TEMP_W-1:0] temperature = '0;
	logic                     out_ready   = 1'b0;
	logic                     in_ready;
	logic                     out_valid;
	logic                     day_closed;
	logic [DAYS_W-1:0]        day_count;
	logic signed [RUN_W-1:0]  day_maximum;
	logic signed [RUN_W-1:0]  day_minimum;
	logic [UNITS_W-1:0]       daily_units;
	logic [ACC_W-1:0]         accumulated_units;
	logic [STAGE_W-1:0]       growth_stage;
	logic [PCT_W-1:0]         progress_percent;
	logic [BAR_W-1:0]         bar_fill;

	// predicted tracker state and register copies
	int     base_c;
	longint thr_c [NUM_THR];
	int     run_max;
	int     run_min;
	longint heat_total;
	int     days_done;
	longint last_units;

	day_result_t pending_results [$];
	int mismatch_count = 0;
	int quiet_cycles   = 0;
	int idle_pct       = 0;
	int stall_pct      = 0;

	growing_degree_day_stage_tracker #(
		.BAR_STEPS  (BAR_STEPS),
		.TOTAL_WIDTH(TOTAL_WIDTH)
	) DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.func             (func),
		.temperature      (temperature),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.day_closed       (day_closed),
		.day_count        (day_count),
		.day_maximum      (day_maximum),
		.day_minimum      (day_minimum),
		.daily_units      (daily_units),
		.accumulated_units(accumulated_units),
		.growth_stage     (growth_stage),
		.progress_percent (progress_percent),
		.bar_fill         (bar_fill)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic reset_predictor();
		base_c = BASE_RESET;
		for (int i = 0; i < NUM_THR; i++) thr_c[i] = THR_RESET[i];
		run_max    = MAX_EMPTY;
		run_min    = MIN_EMPTY;
		heat_total = 0;
		days_done  = 0;
		last_units = 0;
	endtask

	// Advance the predicted state by one request and return the result it gives.
	function automatic day_result_t compute_day_result(input logic f,
			input logic signed [TEMP_W-1:0] t);
		day_result_t r;
		int     tv;
		int     stage;
		longint diff;
		longint units;
		longint shown_max;
		longint shown_min;
		longint pct;
		longint bar;
		tv = t;
		if (f == FUNC_SAMPLE) begin
			if (tv > run_max) run_max = tv;
			if (tv < run_min) run_min = tv;
		end
		shown_max = run_max;
		shown_min = run_min;
		if (f == FUNC_CLOSE) begin
			diff  = longint'(run_max) + longint'(run_min) - 2 * longint'(base_c);
			units = (diff <= 0) ? 0 : diff / 2;
			if (units > UNITS_MAX) units = UNITS_MAX;
			last_units = units;
			if (days_done < DAYS_MAX) days_done++;
			heat_total += units;
			if (heat_total > TOTAL_MAX) heat_total = TOTAL_MAX;
			run_max = MAX_EMPTY;
			run_min = MIN_EMPTY;
		end
		stage = 0;
		for (int i = 0; i < NUM_THR; i++)
			if (thr_c[i] <= heat_total) stage++;
		if (thr_c[NUM_THR-1] == 0) begin
			pct = 100;
			bar = BAR_STEPS;
		end else begin
			pct = (heat_total * 100) / thr_c[NUM_THR-1];
			if (pct > 100) pct = 100;
			bar = (heat_total * BAR_STEPS) / thr_c[NUM_THR-1];
			if (bar > BAR_STEPS) bar = BAR_STEPS;
		end
		r.day_closed        = (f == FUNC_CLOSE);
		r.day_count         = days_done[DAYS_W-1:0];
		r.day_maximum       = shown_max[RUN_W-1:0];
		r.day_minimum       = shown_min[RUN_W-1:0];
		r.daily_units       = last_units[UNITS_W-1:0];
		r.accumulated_units = heat_total[ACC_W-1:0];
		r.growth_stage      = stage[STAGE_W-1:0];
		r.progress_percent  = pct[PCT_W-1:0];
		r.bar_fill          = bar[BAR_W-1:0];
		return r;
	endfunction

	// Base temperature word: the register keeps the low bits, junk above them.
	function automatic logic [THR_W-1:0] base_word(input int value);
		logic [THR_W-1:0] w;
		w = THR_W'($urandom);
		w[TEMP_W-1:0] = value[TEMP_W-1:0];
		return w;
	endfunction

	function automatic logic signed [TEMP_W-1:0] rand_temp();
		int v;
		if ($urandom_range(4) == 0) v = $urandom;
		else v = int'($urandom_range(12500)) - 4000;
		return v[TEMP_W-1:0];
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] data);
		logic signed [TEMP_W-1:0] b;
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		b = data[TEMP_W-1:0];
		if (idx == REG_BASE) base_c = b;
		else if (idx >= REG_THR1 && idx <= REG_THR6) thr_c[idx - REG_THR1] = data;
	endtask

	// Hold the request until accepted, then idle for a random gap.
	task automatic send_request(input logic f, input logic signed [TEMP_W-1:0] t);
		int gap;
		in_valid    <= 1'b1;
		func        <= f;
		temperature <= t;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(compute_day_result(f, t));
		gap = 0;
		while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic check_field(input string name, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_LIMIT)
				$display("%0t: %s expected %0d got %0d", $time, name, want, got);
		end
	endtask

	task automatic check_result();
		day_result_t want;
		if (pending_results.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_LIMIT)
				$display("%0t: unexpected result expected none got day_count %0d",
					$time, day_count);
			return;
		end
		want = pending_results.pop_front();
		check_field("day_closed", want.day_closed, day_closed);
		check_field("day_count", want.day_count, day_count);
		check_field("day_maximum", want.day_maximum, day_maximum);
		check_field("day_minimum", want.day_minimum, day_minimum);
		check_field("daily_units", want.daily_units, daily_units);
		check_field("accumulated_units", want.accumulated_units, accumulated_units);
		check_field("growth_stage", want.growth_stage, growth_stage);
		check_field("progress_percent", want.progress_percent, progress_percent);
		check_field("bar_fill", want.bar_fill, bar_fill);
	endtask

	always @(posedge clk) begin
		if (out_valid && out_ready) check_result();
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic test_reset_defaults();
		send_request(FUNC_CLOSE, rand_temp());
		send_request(FUNC_SAMPLE, 15'sd8500);
		send_request(FUNC_SAMPLE, -15'sd4000);
		send_request(FUNC_SAMPLE, 15'sd1000);
		send_request(FUNC_CLOSE, rand_temp());
		wait_for_results();
	endtask

	task automatic test_field_extremes();
		send_request(FUNC_SAMPLE, -15'sd16384);
		send_request(FUNC_SAMPLE, 15'sd16383);
		send_request(FUNC_SAMPLE, 15'sd0);
		send_request(FUNC_SAMPLE, -15'sd1);
		send_request(FUNC_CLOSE, 15'sd0);
		wait_for_results();
	endtask

	task automatic test_register_extremes();
		logic [THR_W-1:0] levels [NUM_THR];
		levels = '{20'd0, 20'hFFFFF, 20'd1000000, 20'd0, 20'd500, 20'd0};
		// empty day against a low base still earns units
		write_reg(REG_BASE, base_word(-4000));
		send_request(FUNC_CLOSE, rand_temp());
		wait_for_results();
		// drop write to an unmapped index
		write_reg(REG_UNUSED, 20'hFFFFF);
		send_request(FUNC_CLOSE, rand_temp());
		wait_for_results();
		// unordered thresholds with a zero final threshold
		for (int k = 0; k < NUM_THR; k++)
			write_reg(REG_THR1 + CFG_IDX_W'(k), levels[k]);
		send_request(FUNC_SAMPLE, 15'sd8500);
		send_request(FUNC_CLOSE, rand_temp());
		wait_for_results();
		write_reg(REG_THR6, 20'hFFFFF);
		send_request(FUNC_SAMPLE, 15'sd16383);
		send_request(FUNC_SAMPLE, -15'sd16384);
		send_request(FUNC_CLOSE, rand_temp());
		wait_for_results();
		// mean below base clamps to zero
		write_reg(REG_BASE, base_word(8500));
		send_request(FUNC_SAMPLE, -15'sd4000);
		send_request(FUNC_CLOSE, rand_temp());
		wait_for_results();
		write_reg(REG_BASE, base_word(16383));
		send_request(FUNC_CLOSE, rand_temp());
		wait_for_results();
		write_reg(REG_BASE, base_word(-16384));
		send_request(FUNC_CLOSE, rand_temp());
		wait_for_results();
	endtask

	task automatic load_random_setting();
		int pick;
		int v;
		longint span;
		longint lvl;
		longint levels [$];
		pick = $urandom_range(4);
		if (pick == 0) v = -4000;
		else if (pick == 1) v = 8500;
		else v = int'($urandom_range(4000)) - 1000;
		write_reg(REG_BASE, base_word(v));
		if ($urandom_range(4) == 0) begin
			for (int k = 0; k < NUM_THR; k++)
				write_reg(REG_THR1 + CFG_IDX_W'(k), THR_W'($urandom));
		end else begin
			// ascending thresholds drawn at random from zero up to a span above the running total
			span = heat_total + 100000 + $urandom_range(200000);
			for (int k = 0; k < NUM_THR; k++) begin
				lvl = $urandom_range(32'(span));
				if (lvl > UNITS_MAX) lvl = UNITS_MAX;
				levels.push_back(lvl);
			end
			levels.sort();
			for (int k = 0; k < NUM_THR; k++)
				write_reg(REG_THR1 + CFG_IDX_W'(k), levels[k][THR_W-1:0]);
		end
	endtask

	task automatic test_random_days(input int sender_idle, input int receiver_stall,
			input int item_goal);
		int sent;
		int day_len;
		idle_pct  = sender_idle;
		stall_pct = receiver_stall;
		load_random_setting();
		sent = 0;
		while (sent < item_goal) begin
			// mostly full days; some empty days and back-to-back closes
			day_len = ($urandom_range(9) == 0) ? 0 : $urandom_range(12, 1);
			repeat (day_len) send_request(FUNC_SAMPLE, rand_temp());
			send_request(FUNC_CLOSE, rand_temp());
			sent += day_len + 1;
		end
		wait_for_results();
	endtask

	task automatic test_zero_thresholds();
		idle_pct  = 0;
		stall_pct = 0;
		// zero thresholds keep every request on the short path
		write_reg(REG_BASE, base_word(-16384));
		for (int k = 0; k < NUM_THR; k++) write_reg(REG_THR1 + CFG_IDX_W'(k), '0);
		repeat (SHORT_DAYS) send_request(FUNC_CLOSE, rand_temp());
		send_request(FUNC_SAMPLE, rand_temp());
		send_request(FUNC_CLOSE, rand_temp());
		wait_for_results();
	endtask

	initial begin
		reset_predictor();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_field_extremes();
		test_register_extremes();
		test_random_days(0, 0, 300);
		test_random_days(60, 0, 300);
		test_random_days(0, 60, 300);
		test_random_days(7, 7, 300);
		test_zero_thresholds();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: sim.f
+incdir+hdl
hdl/gdd_pkg.sv
hdl/gdd_cmpsub.sv
hdl/gdd_day.sv
hdl/growing_degree_day_stage_tracker.sv
verif/testbench.sv
